// ===== rtl/ebm_pkg.sv =====
// ebm_pkg: shared types, codes and constants for the block mapper
// used by ebm_map_core, erofs_block_mapper and ebm_checker
package ebm_pkg;

	localparam int ADDR_W = 64;
	localparam int NID_W  = 48;
	localparam int WORD_W = 32;
	localparam int XC_W   = 16;
	localparam int LB_W   = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [LB_W-1:0] LOG2_BS_MIN   = 5'd9;
	localparam logic [LB_W-1:0] LOG2_BS_MAX   = 5'd16;
	localparam logic [LB_W-1:0] LOG2_BS_RESET = 5'd12;

	localparam logic [15:0] CHUNK_BITS_MASK = 16'h001F;
	localparam logic [15:0] CHUNK_INDEXES   = 16'h0020;
	localparam logic [6:0]  MAX_CHUNK_BITS  = 7'd63;
	localparam logic [WORD_W-1:0] NULL_BLOCK = 32'd1;

	localparam logic [2:0] LAYOUT_INLINE = 3'd2;
	localparam logic [2:0] LAYOUT_CHUNK  = 3'd4;

	localparam logic OP_MAP   = 1'b0;
	localparam logic OP_REPLY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_LOG2_BS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_META    = 1'b1;

	typedef enum logic [2:0] {
		ST_DONE       = 3'd0,
		ST_OVERFLOW   = 3'd1,
		ST_CORRUPT    = 3'd2,
		ST_NEED_ENTRY = 3'd3,
		ST_NO_PENDING = 3'd4
	} status_t;

	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] logical_addr;
		logic [NID_W-1:0]  inode_nid;
		logic              inode_extended;
		logic [2:0]        data_layout;
		logic [ADDR_W-1:0] file_bytes;
		logic [XC_W-1:0]   xattr_count;
		logic [WORD_W-1:0] layout_word;
		logic [WORD_W-1:0] entry_blkaddr;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic              mapped;
		logic [ADDR_W-1:0] physical_addr;
		logic [ADDR_W-1:0] extent_start;
		logic [ADDR_W-1:0] extent_length;
		logic [ADDR_W-1:0] entry_position;
		logic              entry_wide;
	} result_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] length;
	} pend_t;

endpackage

// ===== rtl/erofs_block_mapper.sv =====
// an accepted word passes the input register and then the result register to become its result word
// throughput: one word per cycle while not stalled; the mapping logic between the two registers is a single pass
// a full result register that is stalled holds the input register, which then stalls the input
// reset (arst_n low, asynchronous): empty pipeline, nothing pending, block size 4096 (log2 12),
// metadata start block 0; configuration writes are always ready
module erofs_block_mapper import ebm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 opcode,
	input  logic [ADDR_W-1:0]    logical_addr,
	input  logic [NID_W-1:0]     inode_nid,
	input  logic                 inode_extended,
	input  logic [2:0]           data_layout,
	input  logic [ADDR_W-1:0]    file_bytes,
	input  logic [XC_W-1:0]      xattr_count,
	input  logic [WORD_W-1:0]    layout_word,
	input  logic [WORD_W-1:0]    entry_blkaddr,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           status,
	output logic                 mapped,
	output logic [ADDR_W-1:0]    physical_addr,
	output logic [ADDR_W-1:0]    extent_start,
	output logic [ADDR_W-1:0]    extent_length,
	output logic [ADDR_W-1:0]    entry_position,
	output logic                 entry_wide
);

	logic [LB_W-1:0]   log2_bs_q;
	logic [WORD_W-1:0] meta_blk_q;
	logic [LB_W-1:0]   lb_wr;
	pend_t             pend_q, pend_nxt;
	logic              valid_s1, valid_s2;
	item_t             item_s1;
	result_t           res_s2, res_c;
	logic              adv1, take_in;

	assign cfg_ready = 1'b1;

	// clamp block size into the supported range
	always_comb begin
		lb_wr = cfg_data[LB_W-1:0];
		if (lb_wr < LOG2_BS_MIN) lb_wr = LOG2_BS_MIN;
		if (lb_wr > LOG2_BS_MAX) lb_wr = LOG2_BS_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_bs_q  <= LOG2_BS_RESET;
			meta_blk_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOG2_BS: log2_bs_q  <= lb_wr;
				CFG_META:    meta_blk_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	assign adv1     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv1;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{opcode, logical_addr, inode_nid, inode_extended, data_layout,
				file_bytes, xattr_count, layout_word, entry_blkaddr};
		end
	end

	ebm_map_core u_core (
		.item     (item_s1),
		.log2_bs  (log2_bs_q),
		.meta_blk (meta_blk_q),
		.pend     (pend_q),
		.res      (res_c),
		.pend_nxt (pend_nxt)
	);

	// pending chunk request moves with the word that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				pend_q <= pend_nxt;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid      = valid_s2;
	assign status         = res_s2.status;
	assign mapped         = res_s2.mapped;
	assign physical_addr  = res_s2.physical_addr;
	assign extent_start   = res_s2.extent_start;
	assign extent_length  = res_s2.extent_length;
	assign entry_position = res_s2.entry_position;
	assign entry_wide     = res_s2.entry_wide;

endmodule

// ===== rtl/ebm_map_core.sv =====
// ebm_map_core: combinational mapping of one registered word to one result
// flat, inline tail and chunk layouts plus chunk entry replies; uses ebm_pkg
module ebm_map_core import ebm_pkg::*; (
	input  item_t              item,
	input  logic [LB_W-1:0]    log2_bs,
	input  logic [WORD_W-1:0]  meta_blk,
	input  pend_t              pend,
	output result_t            res,
	output pend_t              pend_nxt
);

	logic [ADDR_W-1:0] bs, bmask;
	logic [ADDR_W-1:0] la, fs;
	logic [ADDR_W-1:0] xbody, ainode;
	logic              is_tail;
	// flat
	logic [ADDR_W:0]   rnd;
	logic [ADDR_W-1:0] lastend;
	logic [ADDR_W:0]   pa_flat;
	// tail
	logic [ADDR_W-1:0] pa_tail, plen_tail;
	logic [ADDR_W:0]   tail_end;
	// chunk
	logic [15:0]       fmt;
	logic              wide;
	logic [6:0]        cb_sum;
	logic [5:0]        cb;
	logic [ADDR_W-1:0] cnr, cmask, csz, cstart, umask, pos0, pos, plen_c, plen_rnd, plen_ch;

	assign la    = item.logical_addr;
	assign fs    = item.file_bytes;
	assign bs    = 64'd1 << log2_bs;
	assign bmask = bs - 64'd1;

	// byte address right after the inode and its xattr body; cannot wrap at these widths
	assign xbody  = (item.xattr_count == '0) ? '0
		: ({46'd0, item.xattr_count, 2'b00} + 64'd8);
	assign ainode = ({32'd0, meta_blk} << log2_bs)
		+ {11'd0, item.inode_nid, 5'd0}
		+ (item.inode_extended ? 64'd64 : 64'd32)
		+ xbody;

	assign is_tail = (item.data_layout == LAYOUT_INLINE);
	assign rnd     = {1'b0, fs} + {1'b0, bmask};
	assign lastend = (rnd[ADDR_W-1:0] & ~bmask) - (is_tail ? bs : 64'd0);
	assign pa_flat = {1'b0, {32'd0, item.layout_word} << log2_bs} + {1'b0, la};

	assign pa_tail   = ainode + (la & bmask);
	assign plen_tail = fs - la;
	assign tail_end  = {1'b0, pa_tail & bmask} + {1'b0, plen_tail};

	assign fmt     = item.layout_word[15:0];
	assign wide    = (fmt & CHUNK_INDEXES) != '0;
	assign cb_sum  = {2'd0, log2_bs} + {2'd0, fmt[4:0] & CHUNK_BITS_MASK[4:0]};
	assign cb      = cb_sum[5:0];
	assign cnr     = la >> cb;
	assign csz     = 64'd1 << cb;
	assign cmask   = csz - 64'd1;
	assign cstart  = la & ~cmask;
	assign umask   = wide ? 64'd7 : 64'd3;
	assign pos0    = (ainode + umask) & ~umask;
	assign pos     = pos0 + (wide ? {cnr[60:0], 3'b000} : {cnr[61:0], 2'b00});
	assign plen_c  = fs - cstart;
	assign plen_rnd = (plen_c + bmask) & ~bmask;
	assign plen_ch = (plen_c >= csz) ? csz : plen_rnd;

	always_comb begin
		res      = '0;
		res.status = ST_DONE;
		pend_nxt = pend;
		if (item.opcode == OP_REPLY) begin
			if (!pend.valid) begin
				res.status = ST_NO_PENDING;
			end else begin
				pend_nxt.valid    = 1'b0;
				res.extent_start  = pend.start;
				res.extent_length = pend.length;
				if (item.entry_blkaddr != NULL_BLOCK) begin
					res.mapped        = 1'b1;
					res.physical_addr = {32'd0, item.entry_blkaddr} << log2_bs;
				end
			end
		end else begin
			pend_nxt.valid = 1'b0;
			priority if (la >= fs) begin
				res.extent_start = la;
			end else if (item.data_layout != LAYOUT_CHUNK) begin
				priority if (rnd[ADDR_W]) begin
					res.status = ST_OVERFLOW;
				end else if (la < lastend) begin
					if (pa_flat[ADDR_W]) begin
						res.status = ST_OVERFLOW;
					end else begin
						res.mapped        = 1'b1;
						res.physical_addr = pa_flat[ADDR_W-1:0];
						res.extent_start  = la;
						res.extent_length = lastend - la;
					end
				end else if (!is_tail) begin
					res.status = ST_CORRUPT;
				end else if (tail_end > {1'b0, bs}) begin
					// tail data crosses a block boundary
					res.status = ST_CORRUPT;
				end else begin
					res.mapped        = 1'b1;
					res.physical_addr = pa_tail;
					res.extent_start  = la;
					res.extent_length = plen_tail;
				end
			end else if (cb_sum > MAX_CHUNK_BITS) begin
				res.status = ST_CORRUPT;
			end else begin
				res.status         = ST_NEED_ENTRY;
				res.extent_start   = cstart;
				res.extent_length  = plen_ch;
				res.entry_position = pos;
				res.entry_wide     = wide;
				pend_nxt.valid     = 1'b1;
				pend_nxt.start     = cstart;
				pend_nxt.length    = plen_ch;
			end
		end
	end

endmodule

// ===== rtl/ebm_checker.sv =====
// ebm_checker: port-level assertions for erofs_block_mapper, attached by bind
// uses the status codes of ebm_pkg
module ebm_checker import ebm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [2:0]           status,
	input logic                 mapped,
	input logic [ADDR_W-1:0]    physical_addr,
	input logic [ADDR_W-1:0]    extent_start,
	input logic [ADDR_W-1:0]    extent_length,
	input logic [ADDR_W-1:0]    entry_position,
	input logic                 entry_wide
);

	// a stalled result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(extent_start))
		else $error("result word dropped or changed under stall");

	// error words carry nothing else
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OVERFLOW || status == ST_CORRUPT || status == ST_NO_PENDING)
		|-> !mapped && physical_addr == '0 && extent_start == '0 && extent_length == '0)
		else $error("error result with nonzero fields");

	// entry fields only on a chunk entry request
	a_entry_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_NEED_ENTRY |-> entry_position == '0 && !entry_wide)
		else $error("entry fields set outside chunk entry request");

	// a chunk entry request is never mapped yet
	a_need_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NEED_ENTRY |-> !mapped && physical_addr == '0)
		else $error("chunk entry request carries a mapping");

	// an empty result register never stalls the input
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output empty");

endmodule

bind erofs_block_mapper ebm_checker u_ebm_checker (.*);
